// File: rtl/core/random_hyperplane_hash_defines.svh
// assertion macros for the random hyperplane hash rtl
// expects signals clk and rst in the scope of each use
`ifndef RANDOM_HYPERPLANE_HASH_DEFINES_SVH
`define RANDOM_HYPERPLANE_HASH_DEFINES_SVH

`ifndef SYNTHESIS
`define RHH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RHH_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHH_ASSERT(label, prop, msg)
`define RHH_ASSERT_RST(label, prop, msg)
`endif

`endif

// File: rtl/core/rhh_pkg.sv
// shared constants, codes and control struct of the random hyperplane hash
// no dependencies
package rhh_pkg;

  localparam int MAX_PLANES_DEF   = 16;
  localparam int MAX_DIMS_DEF     = 128;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 40;

  localparam int PLANE_IDX_W = 4;
  localparam int DIM_IDX_W   = 7;
  localparam int HASH_W      = 16;
  localparam int PNUM_W      = 16;
  localparam int CFG_W       = 5;

  localparam logic [CFG_W-1:0] PLANE_COUNT_RESET = 5'd16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  // control part of a beat travelling down the plane chain
  typedef struct packed {
    logic valid;
    logic load;
    logic point;
    logic active;
    logic last;
  } rhh_ctrl_t;

endpackage

// File: rtl/core/rhh_sample_if.sv
// input channel: coefficient loads and point components
// depends on rhh_pkg
interface rhh_sample_if #(
  parameter int SAMPLE_WIDTH = rhh_pkg::SAMPLE_WIDTH_DEF
);
  import rhh_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [PLANE_IDX_W-1:0]        plane_index;
  logic [DIM_IDX_W-1:0]          dim_index;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, mode, plane_index, dim_index, value, last, input ready);
  modport sink (input valid, mode, plane_index, dim_index, value, last, output ready);

endinterface

// File: rtl/core/rhh_hash_if.sv
// output channel: one hash code per point
// depends on rhh_pkg
interface rhh_hash_if;
  import rhh_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_code;
  logic [PNUM_W-1:0] point_number;

  modport source (output valid, hash_code, point_number, input ready);
  modport sink (input valid, hash_code, point_number, output ready);

endinterface

// File: rtl/core/rhh_plane_cell.sv
// one hyperplane of the chain: coefficient memory, multiplier, accumulator
// three register stages per beat; depends on rhh_pkg
module rhh_plane_cell #(
  parameter int PLANE_ID     = 0,
  parameter int MAX_PLANES   = rhh_pkg::MAX_PLANES_DEF,
  parameter int MAX_DIMS     = rhh_pkg::MAX_DIMS_DEF,
  parameter int SAMPLE_WIDTH = rhh_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = rhh_pkg::ACC_WIDTH_DEF,
  parameter int DIM_AW       = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  rhh_pkg::rhh_ctrl_t                  ctrl_in,
  input  logic [rhh_pkg::PLANE_IDX_W-1:0]     plane_in,
  input  logic [DIM_AW-1:0]                   addr_in,
  input  logic signed [SAMPLE_WIDTH-1:0]      value_in,
  input  logic [MAX_PLANES-1:0]               hash_in,
  output rhh_pkg::rhh_ctrl_t                  ctrl_out,
  output logic [rhh_pkg::PLANE_IDX_W-1:0]     plane_out,
  output logic [DIM_AW-1:0]                   addr_out,
  output logic signed [SAMPLE_WIDTH-1:0]      value_out,
  output logic [MAX_PLANES-1:0]               hash_out
);
  import rhh_pkg::*;

  localparam int PW = 2 * SAMPLE_WIDTH;
  localparam int EW = (ACC_WIDTH > PW) ? ACC_WIDTH : PW;

  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_DIMS];

  rhh_ctrl_t                      ctrl_a, ctrl_b, ctrl_c;
  logic [PLANE_IDX_W-1:0]         plane_a, plane_b, plane_c;
  logic [DIM_AW-1:0]              addr_a, addr_b, addr_c;
  logic signed [SAMPLE_WIDTH-1:0] value_a, value_b, value_c;
  logic [MAX_PLANES-1:0]          hash_a, hash_b, hash_c;
  logic signed [SAMPLE_WIDTH-1:0] coef_a;
  logic signed [PW-1:0]           prod_b;
  logic [ACC_WIDTH-1:0]           acc;

  logic                 wr_en;
  logic                 use_a;
  logic signed [PW-1:0] prod_mul;
  logic signed [EW-1:0] prod_ext;
  logic [ACC_WIDTH-1:0] acc_sum;
  logic                 hit;
  logic [MAX_PLANES-1:0] hash_set;

  assign wr_en = advance && ctrl_in.valid && ctrl_in.load && ctrl_in.active &&
                 (32'(plane_in) == PLANE_ID);
  assign use_a = ctrl_a.valid && ctrl_a.point && ctrl_a.active;

  // stage a: coefficient store
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a <= '0;
    end else if (advance) begin
      ctrl_a <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[addr_in] <= value_in;
    end
    if (advance) begin
      coef_a  <= coef_mem[addr_in];
      plane_a <= plane_in;
      addr_a  <= addr_in;
      value_a <= value_in;
      hash_a  <= hash_in;
    end
  end

  // stage b: product
  assign prod_mul = coef_a * value_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_b <= '0;
    end else if (advance) begin
      ctrl_b <= ctrl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_b  <= use_a ? prod_mul : '0;
      plane_b <= plane_a;
      addr_b  <= addr_a;
      value_b <= value_a;
      hash_b  <= hash_a;
    end
  end

  // stage c: accumulate, sign test against the updated sum
  assign prod_ext = EW'(prod_b);
  assign acc_sum  = acc + prod_ext[ACC_WIDTH-1:0];
  assign hit      = (acc_sum != '0) && !acc_sum[ACC_WIDTH-1];

  always_comb begin
    hash_set           = hash_b;
    hash_set[PLANE_ID] = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_c <= '0;
      acc    <= '0;
    end else if (advance) begin
      ctrl_c <= ctrl_b;
      if (ctrl_b.valid && ctrl_b.point) begin
        acc <= ctrl_b.last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      plane_c <= plane_b;
      addr_c  <= addr_b;
      value_c <= value_b;
      hash_c  <= hash_set;
    end
  end

  assign ctrl_out  = ctrl_c;
  assign plane_out = plane_c;
  assign addr_out  = addr_c;
  assign value_out = value_c;
  assign hash_out  = hash_c;

endmodule

// File: rtl/core/random_hyperplane_hash.sv
// the beat with last passes the stages of every plane cell, then the output register
// throughput: one beat per cycle while the chain advances; a stall holds every cell
// the chain stalls only when a hash reaches the end while the output register is held
// reset clears accumulators, counters, output valid and sets plane_count to 16
// the coefficient memories are not cleared and hold garbage until loaded
module random_hyperplane_hash #(
  parameter int MAX_PLANES   = rhh_pkg::MAX_PLANES_DEF,
  parameter int MAX_DIMS     = rhh_pkg::MAX_DIMS_DEF,
  parameter int SAMPLE_WIDTH = rhh_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = rhh_pkg::ACC_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  rhh_sample_if.sink                sample_ch,
  rhh_hash_if.source                hash_ch,
  input  logic                      cfg_we,
  input  logic [rhh_pkg::CFG_W-1:0] cfg_wdata
);
  import rhh_pkg::*;

  `include "random_hyperplane_hash_defines.svh"

  localparam int DIM_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W  = $clog2(MAX_DIMS + 1);
  localparam int HW     = (MAX_PLANES > HASH_W) ? MAX_PLANES : HASH_W;

  logic [CFG_W-1:0]  plane_count;
  logic [CNT_W-1:0]  comp_cnt;
  logic [PNUM_W-1:0] point_cnt;
  logic              out_valid;
  logic [HASH_W-1:0] out_hash;
  logic [PNUM_W-1:0] out_pnum;

  rhh_ctrl_t                      ctrl_ch  [MAX_PLANES+1];
  logic [PLANE_IDX_W-1:0]         plane_ch [MAX_PLANES+1];
  logic [DIM_AW-1:0]              addr_ch  [MAX_PLANES+1];
  logic signed [SAMPLE_WIDTH-1:0] value_ch [MAX_PLANES+1];
  logic [MAX_PLANES-1:0]          hash_ch_v [MAX_PLANES+1];

  logic                        advance;
  logic                        accept;
  logic                        is_point;
  logic                        dim_ok;
  logic                        comp_ok;
  logic [DIM_AW+DIM_IDX_W-1:0] dim_wide;
  logic                        out_load;
  logic [HW-1:0]               hash_wide;
  logic [HASH_W-1:0]           count_mask;

  // the chain holds only when a hash arrives at the end and cannot be stored
  assign out_load = ctrl_ch[MAX_PLANES].valid && ctrl_ch[MAX_PLANES].point &&
                    ctrl_ch[MAX_PLANES].last;
  assign advance  = !(out_load && out_valid && !hash_ch.ready);
  assign sample_ch.ready = advance;
  assign accept   = sample_ch.valid && advance;
  assign is_point = (sample_ch.mode == MODE_POINT);

  assign dim_wide = {{DIM_AW{1'b0}}, sample_ch.dim_index};
  assign dim_ok   = 32'(sample_ch.dim_index) < MAX_DIMS;
  assign comp_ok  = 32'(comp_cnt) < MAX_DIMS;

  always_comb begin
    ctrl_ch[0].valid  = accept;
    ctrl_ch[0].load   = !is_point;
    ctrl_ch[0].point  = is_point;
    ctrl_ch[0].active = is_point ? comp_ok : dim_ok;
    ctrl_ch[0].last   = sample_ch.last;
    plane_ch[0]       = sample_ch.plane_index;
    addr_ch[0]        = is_point ? comp_cnt[DIM_AW-1:0] : dim_wide[DIM_AW-1:0];
    value_ch[0]       = sample_ch.value;
    hash_ch_v[0]      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_cnt <= '0;
    end else if (accept && is_point) begin
      if (sample_ch.last) begin
        comp_cnt <= '0;
      end else if (comp_ok) begin
        comp_cnt <= comp_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= PLANE_COUNT_RESET;
    end else if (cfg_we) begin
      plane_count <= cfg_wdata;
    end
  end

  for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
    rhh_plane_cell #(
      .PLANE_ID     (p),
      .MAX_PLANES   (MAX_PLANES),
      .MAX_DIMS     (MAX_DIMS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_WIDTH    (ACC_WIDTH),
      .DIM_AW       (DIM_AW)
    ) u_plane (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .ctrl_in   (ctrl_ch[p]),
      .plane_in  (plane_ch[p]),
      .addr_in   (addr_ch[p]),
      .value_in  (value_ch[p]),
      .hash_in   (hash_ch_v[p]),
      .ctrl_out  (ctrl_ch[p+1]),
      .plane_out (plane_ch[p+1]),
      .addr_out  (addr_ch[p+1]),
      .value_out (value_ch[p+1]),
      .hash_out  (hash_ch_v[p+1])
    );
  end

  // keep only the planes in use, bits 16 and above fall off
  always_comb begin
    hash_wide = HW'(hash_ch_v[MAX_PLANES]);
    for (int j = 0; j < HASH_W; j++) begin
      count_mask[j] = (j < int'(plane_count)) && (j < MAX_PLANES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      point_cnt <= '0;
    end else begin
      if (out_load && advance) begin
        out_valid <= 1'b1;
        point_cnt <= point_cnt + 1'b1;
      end else if (hash_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && advance) begin
      out_hash <= hash_wide[HASH_W-1:0] & count_mask;
      out_pnum <= point_cnt;
    end
  end

  assign hash_ch.valid        = out_valid;
  assign hash_ch.hash_code    = out_hash;
  assign hash_ch.point_number = out_pnum;

  `RHH_ASSERT_RST(a_rst_idle, rst |=> !hash_ch.valid && point_cnt == '0, "reset left state")
  `RHH_ASSERT(a_no_overwrite, out_load && advance |-> !out_valid || hash_ch.ready, "hash lost")
  `RHH_ASSERT(a_pnum_step, out_load && advance |=> point_cnt == $past(point_cnt) + 1'b1, "point count skip")
  `RHH_ASSERT(a_mask, hash_ch.valid |-> (hash_ch.hash_code & ~count_mask) == '0, "unused plane bit set")

endmodule
